>>> hw/rtl/lbp_pkg.sv
// Package for the LBP code histogram: item types, codes and sizes.
package lbp_pkg;

  // Default frame limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int DIM_MIN        = 3;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int PIX_W  = 8;
  localparam int CODE_W = 8;
  localparam int POS_W  = 10;
  localparam int BIN_W  = 20;
  localparam int CFG_W  = 11;
  localparam int CFG_IDX_W = 1;

  // Histogram geometry
  localparam int NUM_BINS = 256;
  localparam int BIN_AW   = $clog2(NUM_BINS);
  localparam logic [BIN_W-1:0] BIN_MAX = '1;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd1024;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  // Result kinds
  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // Operation held in the first pipeline stage
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PIXEL,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [PIX_W-1:0] pixel;
    logic [BIN_AW-1:0] bin_index;
  } in_t;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] lbp_code;
    logic [POS_W-1:0]  code_row;
    logic [POS_W-1:0]  code_col;
    logic              frame_last;
    logic [BIN_W-1:0]  bin_count;
  } out_t;

  // Request from stage 1 to the histogram unit
  typedef struct packed {
    logic              rd;
    logic              inc;
    logic              clr;
    logic [BIN_AW-1:0] addr;
  } hist_req_t;

endpackage

>>> hw/rtl/lbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/lbp_hist.sv
// Code histogram: read-modify-write of bin counts with forwarding and bulk clear.
module lbp_hist (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  lbp_pkg::hist_req_t       req,
  output logic [lbp_pkg::BIN_W-1:0] count
);
  import lbp_pkg::*;

  hist_req_t         req2;
  logic [NUM_BINS-1:0] vld;
  logic              fwd_hit;
  logic [BIN_W-1:0]  fwd_data;
  logic [BIN_W-1:0]  rdata;
  logic [BIN_W-1:0]  inc_val;
  logic              rd_en;
  logic              wr_en;
  logic              hit_next;

  // Read issued from stage 1, write back from stage 2
  assign rd_en = adv && (req.rd || req.inc);
  assign wr_en = adv && req2.inc;

  // Forwarded value wins; a bin not written since the last clear reads zero
  assign count   = fwd_hit ? fwd_data : (vld[req2.addr] ? rdata : '0);
  assign inc_val = (count == BIN_MAX) ? count : count + BIN_W'(1);

  // Same bin written back while the next item reads it
  assign hit_next = req2.inc && (req.rd || req.inc) && (req.addr == req2.addr);

  lbp_ram #(
    .WIDTH (BIN_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (wr_en),
    .waddr (req2.addr),
    .wdata (inc_val),
    .re    (rd_en),
    .raddr (req.addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req2    <= '0;
      vld     <= '0;
      fwd_hit <= 1'b0;
    end else if (adv) begin
      req2     <= req;
      fwd_hit  <= hit_next;
      fwd_data <= inc_val;
      if (req2.clr) begin
        vld <= '0;
      end else if (req2.inc) begin
        vld[req2.addr] <= 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/lbp_code_histogram.sv
// Streaming 3x3 LBP coder with line buffers and a saturating code histogram.
// Pipeline: an accepted item passes the stage 1 and stage 2 registers before its result enters the output register.
// Throughput: one item per cycle unless a stalled output holds the pipe; the line-buffer and histogram RAMs each do one
// read and one write per cycle, with forwarding on back-to-back hits to the same bin.
// Reset: positions and stages cleared; histogram bins clear through their valid bits;
// line buffers read as zero at or above a fill mark, so no clearing pass is needed.
module lbp_code_histogram #(
  parameter int MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lbp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lbp_pkg::in_t                  in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lbp_pkg::out_t                 out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbp_pkg::CFG_W-1:0]     cfg_data
);
  import lbp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  // Configuration and effective frame size
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [WW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;

  // Position counters and accept-side decode
  logic [CW-1:0] col, col_next, c0;
  logic [RW-1:0] row, row_next, r_cl;
  logic          close_row, ignore_px, end_row;
  op_t           op_in;
  logic          adv, accept, lb_re;

  // Stage 1
  op_t              s1_op;
  logic [PIX_W-1:0] s1_px;
  logic [BIN_AW-1:0] s1_bin;
  logic [CW-1:0]    s1_addr;
  logic             s1_lb_ok;
  logic             s1_code_en;
  logic [POS_W-1:0] s1_row, s1_col;
  logic             s1_last;
  logic [PIX_W-1:0] up_q, mid_q, up_v, mid_v;
  logic [PIX_W-1:0] win [6];
  logic [CODE_W-1:0] code;
  logic [WW-1:0]    fill;
  logic             lb_we;
  hist_req_t        hreq;

  // Stage 2
  logic              s2_res;
  logic              s2_kind;
  logic [CODE_W-1:0] s2_code;
  logic [POS_W-1:0]  s2_row, s2_col;
  logic              s2_last;
  logic [BIN_W-1:0]  count;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp frame size to the supported range
  always_comb begin
    if (image_width < CFG_W'(DIM_MIN)) begin
      w_eff = WW'(DIM_MIN);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height < CFG_W'(DIM_MIN)) begin
      h_eff = RW'(DIM_MIN);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(image_height);
    end
  end

  // The whole pipe moves unless a result in stage 2 meets a full, stalled output
  assign adv      = !out_valid || !out_stall || !s2_res;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Position of the incoming pixel, row close on a shrunk width, next position
  always_comb begin
    close_row = (WW'(col) >= w_eff);
    c0        = close_row ? '0 : col;
    r_cl      = (close_row && (row < h_eff)) ? row + RW'(1) : row;
    ignore_px = (r_cl >= h_eff);
    end_row   = (WW'(c0) + WW'(1) >= w_eff);
    col_next  = col;
    row_next  = row;
    op_in     = OP_NONE;
    case (in_item.cmd)
      CMD_PIXEL: begin
        if (ignore_px) begin
          col_next = c0;
          row_next = r_cl;
        end else begin
          op_in = OP_PIXEL;
          if (end_row) begin
            col_next = '0;
            row_next = r_cl + RW'(1);
          end else begin
            col_next = c0 + CW'(1);
            row_next = r_cl;
          end
        end
      end
      CMD_READ:  op_in = OP_READ;
      CMD_START: begin
        op_in    = OP_CLEAR;
        col_next = '0;
        row_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Line buffers: read at accept, written back from stage 1
  assign lb_re = accept && (op_in == OP_PIXEL);
  assign lb_we = adv && (s1_op == OP_PIXEL);

  lbp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk   (clk),
    .we    (lb_we),
    .waddr (s1_addr),
    .wdata (mid_v),
    .re    (lb_re),
    .raddr (c0),
    .rdata (up_q)
  );

  lbp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_middle (
    .clk   (clk),
    .we    (lb_we),
    .waddr (s1_addr),
    .wdata (s1_px),
    .re    (lb_re),
    .raddr (c0),
    .rdata (mid_q)
  );

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_op <= OP_NONE;
    end else if (adv) begin
      s1_op <= accept ? op_in : OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px      <= in_item.pixel;
      s1_bin     <= in_item.bin_index;
      s1_addr    <= c0;
      s1_lb_ok   <= (WW'(c0) < fill);
      s1_code_en <= (r_cl >= RW'(2)) && (c0 >= CW'(2));
      s1_row     <= POS_W'(r_cl - RW'(2));
      s1_col     <= POS_W'(c0 - CW'(2));
      s1_last    <= (r_cl + RW'(1) == h_eff) && (WW'(c0) + WW'(1) == w_eff);
    end
  end

  // Entries at or above the fill mark were never written and read as zero
  assign up_v  = s1_lb_ok ? up_q  : '0;
  assign mid_v = s1_lb_ok ? mid_q : '0;

  // Pattern code: clockwise from top-left, neighbor >= center sets the bit
  always_comb begin
    code[7] = (win[0] >= win[4]);
    code[6] = (win[3] >= win[4]);
    code[5] = (up_v   >= win[4]);
    code[4] = (mid_v  >= win[4]);
    code[3] = (s1_px  >= win[4]);
    code[2] = (win[5] >= win[4]);
    code[1] = (win[2] >= win[4]);
    code[0] = (win[1] >= win[4]);
  end

  // Window shift and fill mark on every processed pixel
  always_ff @(posedge clk) begin
    if (lb_we) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= up_v;
      win[4] <= mid_v;
      win[5] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (lb_we && (WW'(s1_addr) + WW'(1) > fill)) begin
      fill <= WW'(s1_addr) + WW'(1);
    end
  end

  // Histogram request from stage 1
  always_comb begin
    hreq.rd   = (s1_op == OP_READ);
    hreq.inc  = (s1_op == OP_PIXEL) && s1_code_en;
    hreq.clr  = (s1_op == OP_CLEAR);
    hreq.addr = (s1_op == OP_READ) ? s1_bin : code;
  end

  lbp_hist u_hist (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .req   (hreq),
    .count (count)
  );

  // Stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_res <= 1'b0;
    end else if (adv) begin
      s2_res <= hreq.rd || hreq.inc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind <= hreq.rd ? KIND_COUNT : KIND_CODE;
      s2_code <= code;
      s2_row  <= s1_row;
      s2_col  <= s1_col;
      s2_last <= s1_last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (adv && s2_res) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_res) begin
      out_item.kind <= s2_kind;
      if (s2_kind == KIND_COUNT) begin
        out_item.lbp_code   <= '0;
        out_item.code_row   <= '0;
        out_item.code_col   <= '0;
        out_item.frame_last <= 1'b0;
        out_item.bin_count  <= count;
      end else begin
        out_item.lbp_code   <= s2_code;
        out_item.code_row   <= s2_row;
        out_item.code_col   <= s2_col;
        out_item.frame_last <= s2_last;
        out_item.bin_count  <= '0;
      end
    end
  end

endmodule
